// File: sv/sz_pkg.sv
// ============================================================================
// sz_pkg
// Shared types and constants for the safe-zone stop level block.
// ============================================================================
package sz_pkg;

    // Field and register widths
    localparam int PRICE_W    = 31;
    localparam int DW_W       = 7;
    localparam int MW_W       = 5;
    localparam int MULT_W     = 16;
    localparam int MULT_FRAC  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SEEN_W     = 8;

    // Parameter defaults
    localparam int MAX_DOWN_WINDOW_DEF = 64;
    localparam int MAX_CANDIDATES_DEF  = 16;

    // Register reset values
    localparam logic [DW_W-1:0]   DOWN_WINDOW_RST = 7'd10;
    localparam logic [MW_W-1:0]   MAX_WINDOW_RST  = 5'd3;
    localparam logic [MULT_W-1:0] MULTIPLIER_RST  = 16'd512;

    // Sample counter saturates here
    localparam logic [SEEN_W-1:0] SEEN_LIMIT = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOWN_WINDOW = 2'd0,
        CFG_MAX_WINDOW  = 2'd1,
        CFG_MULTIPLIER  = 2'd2
    } t_cfg_idx;

    // Item sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MOVE,
        SEQ_START,
        SEQ_OFFSET,
        SEQ_CAND,
        SEQ_SCAN,
        SEQ_TAIL,
        SEQ_EMIT
    } t_seq_state;

    // Offset unit states
    typedef enum logic [1:0] {
        OFF_IDLE,
        OFF_MUL,
        OFF_DIV,
        OFF_DONE
    } t_off_state;

    // Offset unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_off_status;

    // Sequencer control strobes
    typedef struct packed {
        logic in_ready;
        logic down_re;
        logic down_we;
        logic off_start;
        logic cand_we;
        logic cand_re;
        logic out_load;
    } t_seq_ctrl;

endpackage

// File: sv/sz_price_if.sv
// ============================================================================
// sz_price_if
// Valid/ready channel carrying one price sample per transfer.
// ============================================================================
interface sz_price_if;

    logic                       valid;
    logic                       ready;
    logic [sz_pkg::PRICE_W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);

endinterface

// File: sv/sz_stop_if.sv
// ============================================================================
// sz_stop_if
// Valid/ready channel carrying one stop level per transfer.
// ============================================================================
interface sz_stop_if;

    logic                       valid;
    logic                       ready;
    logic [sz_pkg::PRICE_W-1:0] stop_level;

    modport source (output valid, output stop_level, input ready);
    modport sink   (input valid, input stop_level, output ready);

endinterface

// File: sv/sz_ram.sv
// ============================================================================
// sz_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module sz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/sz_offset.sv
// ============================================================================
// sz_offset
// Bit-serial offset unit: floor(mult * sum / (count * 2^MULT_FRAC)).
// Shift-add multiply one multiplier bit per cycle, then restoring division
// one quotient bit per cycle.
// ============================================================================
module sz_offset #(
    parameter int SUM_W = 37,
    parameter int CNT_W = 6,
    parameter int DIV_W = SUM_W + sz_pkg::MULT_W - sz_pkg::MULT_FRAC
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SUM_W-1:0]          i_sum,
    input  logic [sz_pkg::MULT_W-1:0] i_mult,
    input  logic [CNT_W-1:0]          i_count,
    output logic [DIV_W-1:0]          o_offset,
    output sz_pkg::t_off_status       o_stat
);

    localparam int PROD_W = SUM_W + sz_pkg::MULT_W;
    localparam int STEP_W = $clog2(DIV_W);

    sz_pkg::t_off_state r_state;
    sz_pkg::t_off_state n_state;
    logic [STEP_W-1:0]  r_step;

    logic [PROD_W-1:0]         r_mcand;
    logic [sz_pkg::MULT_W-1:0] r_mplier;
    logic [PROD_W-1:0]         r_acc;
    logic [PROD_W-1:0]         n_acc;
    logic [DIV_W-1:0]          r_quo;
    logic [CNT_W:0]            r_rem;
    logic [CNT_W-1:0]          r_div;

    logic [CNT_W:0] w_rem_sh;
    logic           w_ge;
    logic [CNT_W:0] n_rem;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sz_pkg::OFF_IDLE: begin
                if (i_start) begin
                    n_state = sz_pkg::OFF_MUL;
                end
            end
            sz_pkg::OFF_MUL: begin
                if (r_step == '0) begin
                    n_state = sz_pkg::OFF_DIV;
                end
            end
            sz_pkg::OFF_DIV: begin
                if (r_step == '0) begin
                    n_state = sz_pkg::OFF_DONE;
                end
            end
            sz_pkg::OFF_DONE: begin
                n_state = sz_pkg::OFF_IDLE;
            end
            default: begin
                n_state = sz_pkg::OFF_IDLE;
            end
        endcase
    end

    // Status outputs
    always_comb begin
        o_stat.busy = (r_state != sz_pkg::OFF_IDLE);
        o_stat.done = (r_state == sz_pkg::OFF_DONE);
    end

    // Multiply step: add the shifted multiplicand when the low bit is set
    assign n_acc = r_mplier[0] ? (r_acc + r_mcand) : r_acc;

    // Divide step: shift in the next dividend bit, subtract if it fits
    assign w_rem_sh = {r_rem[CNT_W-1:0], r_quo[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign n_rem    = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sz_pkg::OFF_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                sz_pkg::OFF_IDLE: begin
                    r_step <= STEP_W'(sz_pkg::MULT_W - 1);
                end
                sz_pkg::OFF_MUL: begin
                    if (r_step == '0) begin
                        r_step <= STEP_W'(DIV_W - 1);
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                sz_pkg::OFF_DIV: begin
                    if (r_step != '0) begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: begin
                    r_step <= '0;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            sz_pkg::OFF_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(i_sum);
                    r_mplier <= i_mult;
                    r_acc    <= '0;
                    r_div    <= i_count;
                end
            end
            sz_pkg::OFF_MUL: begin
                r_acc    <= n_acc;
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[sz_pkg::MULT_W-1:1]};
                if (r_step == '0) begin
                    // drop the multiplier fraction bits and start dividing
                    r_quo <= n_acc[PROD_W-1:sz_pkg::MULT_FRAC];
                    r_rem <= '0;
                end
            end
            sz_pkg::OFF_DIV: begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_offset = r_quo;

endmodule

// File: sv/safezone_stop_level.sv
// ============================================================================
// safezone_stop_level
// Long-side safe-zone stop level over a stream of price samples.
// ============================================================================
// Each sample takes the sequencer from idle to the move state; once the down
//   window is full it goes on through start, offset (only when a downward move
//   is held) and candidate, and when a result is due through scan, tail and emit.
// Samples are taken one at a time: the input is ready only while idle, and a
//   result waits in the emit state until the output register is free.
// Reset: synchronous, active low; registers to 10, 3 and 2.0, rings not cleared.
// ============================================================================
module safezone_stop_level #(
    parameter int MAX_DOWN_WINDOW = sz_pkg::MAX_DOWN_WINDOW_DEF,
    parameter int MAX_CANDIDATES  = sz_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sz_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sz_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sz_price_if.sink                      i_price_ch,
    sz_stop_if.source                     o_stop_ch
);

    localparam int PRICE_W = sz_pkg::PRICE_W;
    localparam int LEN_W   = $clog2(MAX_DOWN_WINDOW);
    localparam int CNT_W   = LEN_W;
    localparam int CA_W    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW_W    = $clog2(MAX_CANDIDATES + 1);
    localparam int SUM_W   = PRICE_W + LEN_W;
    localparam int DIV_W   = SUM_W + sz_pkg::MULT_W - sz_pkg::MULT_FRAC;
    localparam int DWX_W   = (sz_pkg::DW_W > LEN_W + 1) ? sz_pkg::DW_W : LEN_W + 1;
    localparam int MWX_W   = (sz_pkg::MW_W > CW_W) ? sz_pkg::MW_W : CW_W;
    localparam int CMP_W   = ((LEN_W > sz_pkg::SEEN_W) ? LEN_W : sz_pkg::SEEN_W) + 2;

    // Configuration registers
    logic [sz_pkg::DW_W-1:0]   r_down_window;
    logic [sz_pkg::MW_W-1:0]   r_max_window;
    logic [sz_pkg::MULT_W-1:0] r_multiplier;
    logic                      w_cfg_hit;

    // Stream state
    sz_pkg::t_seq_state        r_state;
    sz_pkg::t_seq_state        n_state;
    sz_pkg::t_seq_ctrl         w_ctl;
    logic [sz_pkg::SEEN_W-1:0] r_seen;
    logic [sz_pkg::SEEN_W-1:0] r_t;
    logic [PRICE_W-1:0]        r_prev;
    logic [PRICE_W-1:0]        r_price;
    logic [SUM_W-1:0]          r_sum;
    logic [CNT_W-1:0]          r_count;
    logic [LEN_W-1:0]          r_down_pos;
    logic [CA_W-1:0]           r_cand_pos;
    logic [PRICE_W-1:0]        r_cand;
    logic [CA_W-1:0]           r_scan_k;
    logic                      r_rd_vld;
    logic [PRICE_W-1:0]        r_best;
    logic                      r_out_vld;
    logic [PRICE_W-1:0]        r_out_data;

    // Derived window sizes
    logic [DWX_W-1:0] w_dw_x;
    logic [DWX_W-1:0] w_dw_sat;
    logic [LEN_W-1:0] w_len;
    logic [MWX_W-1:0] w_mw_x;
    logic [MWX_W-1:0] w_mw_sat;
    logic [CW_W-1:0]  w_width;

    // Per-sample datapath
    logic               w_accept;
    logic               w_has_prev;
    logic               w_evict;
    logic               w_cand_full;
    logic               w_emit_due;
    logic               w_out_free;
    logic [PRICE_W-1:0] w_move;
    logic [PRICE_W-1:0] w_old;
    logic [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]   n_count;
    logic [LEN_W:0]     w_pos_inc;
    logic [LEN_W-1:0]   n_down_pos;
    logic [CA_W:0]      w_cpos_inc;
    logic [CA_W-1:0]    n_cand_pos;
    logic [PRICE_W-1:0] w_cand_rd;
    logic [DIV_W-1:0]   w_offset;
    logic [PRICE_W-1:0] w_cand_calc;
    logic               w_scan_last;
    sz_pkg::t_off_status w_off_stat;

    // Saturate the window registers into their legal ranges
    always_comb begin
        w_dw_x = DWX_W'(r_down_window);
        if (w_dw_x < DWX_W'(2)) begin
            w_dw_sat = DWX_W'(2);
        end else if (w_dw_x > DWX_W'(MAX_DOWN_WINDOW)) begin
            w_dw_sat = DWX_W'(MAX_DOWN_WINDOW);
        end else begin
            w_dw_sat = w_dw_x;
        end
        w_len = LEN_W'(w_dw_sat - DWX_W'(1));

        w_mw_x = MWX_W'(r_max_window);
        if (w_mw_x < MWX_W'(1)) begin
            w_mw_sat = MWX_W'(1);
        end else if (w_mw_x > MWX_W'(MAX_CANDIDATES)) begin
            w_mw_sat = MWX_W'(MAX_CANDIDATES);
        end else begin
            w_mw_sat = w_mw_x;
        end
        w_width = CW_W'(w_mw_sat);
    end

    // Stage conditions from the latched sample index
    assign w_accept    = i_price_ch.valid && w_ctl.in_ready;
    assign w_has_prev  = (r_t != '0);
    assign w_evict     = w_has_prev && ((CMP_W'(r_t) - CMP_W'(1)) >= CMP_W'(w_len));
    assign w_cand_full = (CMP_W'(r_t) >= CMP_W'(w_len));
    assign w_emit_due  = (CMP_W'(r_t) >= (CMP_W'(w_len) + CMP_W'(w_width) - CMP_W'(1)));
    assign w_out_free  = !r_out_vld || o_stop_ch.ready;

    // Downward move window update
    assign w_move = (r_prev > r_price) ? (r_prev - r_price) : '0;
    always_comb begin
        n_sum   = r_sum - (w_evict ? SUM_W'(w_old) : '0)
                        + (w_has_prev ? SUM_W'(w_move) : '0);
        n_count = r_count
                  - CNT_W'(w_evict && (w_old != '0) && (r_count != '0))
                  + CNT_W'(w_has_prev && (w_move != '0));
    end

    // Ring position wrap
    assign w_pos_inc  = {1'b0, r_down_pos} + 1'b1;
    assign n_down_pos = (w_pos_inc >= (LEN_W + 1)'(w_len)) ? '0 : w_pos_inc[LEN_W-1:0];
    assign w_cpos_inc = {1'b0, r_cand_pos} + 1'b1;
    assign n_cand_pos = ((CW_W + 1)'(w_cpos_inc) >= (CW_W + 1)'(w_width))
                        ? '0 : w_cpos_inc[CA_W-1:0];

    // Candidate: price less offset, floored at zero (only positives can win)
    assign w_cand_calc = (w_offset > DIV_W'(r_price))
                         ? '0 : (r_price - w_offset[PRICE_W-1:0]);

    assign w_scan_last = ((CW_W + 1)'(r_scan_k) == ((CW_W + 1)'(w_width) - 1'b1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sz_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    n_state = sz_pkg::SEQ_MOVE;
                end
            end
            sz_pkg::SEQ_MOVE: begin
                n_state = w_cand_full ? sz_pkg::SEQ_START : sz_pkg::SEQ_IDLE;
            end
            sz_pkg::SEQ_START: begin
                n_state = (r_count != '0) ? sz_pkg::SEQ_OFFSET : sz_pkg::SEQ_CAND;
            end
            sz_pkg::SEQ_OFFSET: begin
                if (w_off_stat.done) begin
                    n_state = sz_pkg::SEQ_CAND;
                end
            end
            sz_pkg::SEQ_CAND: begin
                n_state = w_emit_due ? sz_pkg::SEQ_SCAN : sz_pkg::SEQ_IDLE;
            end
            sz_pkg::SEQ_SCAN: begin
                if (w_scan_last) begin
                    n_state = sz_pkg::SEQ_TAIL;
                end
            end
            sz_pkg::SEQ_TAIL: begin
                n_state = sz_pkg::SEQ_EMIT;
            end
            sz_pkg::SEQ_EMIT: begin
                if (w_out_free) begin
                    n_state = sz_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_state = sz_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Control strobes
    always_comb begin
        w_ctl = '0;
        case (r_state)
            sz_pkg::SEQ_IDLE: begin
                w_ctl.in_ready = 1'b1;
                w_ctl.down_re  = 1'b1;
            end
            sz_pkg::SEQ_MOVE: begin
                w_ctl.down_we = w_has_prev;
            end
            sz_pkg::SEQ_START: begin
                w_ctl.off_start = (r_count != '0);
            end
            sz_pkg::SEQ_CAND: begin
                w_ctl.cand_we = 1'b1;
            end
            sz_pkg::SEQ_SCAN: begin
                w_ctl.cand_re = 1'b1;
            end
            sz_pkg::SEQ_EMIT: begin
                w_ctl.out_load = w_out_free;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // Configuration write decode
    always_comb begin
        case (i_cfg_idx)
            sz_pkg::CFG_DOWN_WINDOW: w_cfg_hit = i_cfg_wr_en;
            sz_pkg::CFG_MAX_WINDOW:  w_cfg_hit = i_cfg_wr_en;
            sz_pkg::CFG_MULTIPLIER:  w_cfg_hit = i_cfg_wr_en;
            default:                 w_cfg_hit = 1'b0;
        endcase
    end

    // Control state and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sz_pkg::SEQ_IDLE;
            r_out_vld     <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_seen        <= '0;
            r_prev        <= '0;
            r_sum         <= '0;
            r_count       <= '0;
            r_down_pos    <= '0;
            r_cand_pos    <= '0;
            r_down_window <= sz_pkg::DOWN_WINDOW_RST;
            r_max_window  <= sz_pkg::MAX_WINDOW_RST;
            r_multiplier  <= sz_pkg::MULTIPLIER_RST;
        end else begin
            r_state <= n_state;

            // output register: load a result or drop it once transferred
            if (w_ctl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_stop_ch.ready) begin
                r_out_vld <= 1'b0;
            end

            if (w_accept) begin
                r_seen <= (r_seen == sz_pkg::SEEN_LIMIT) ? r_seen : r_seen + 1'b1;
            end

            if (r_state == sz_pkg::SEQ_MOVE) begin
                r_prev  <= r_price;
                r_sum   <= n_sum;
                r_count <= n_count;
                if (w_has_prev) begin
                    r_down_pos <= n_down_pos;
                end
            end

            if (w_ctl.cand_we) begin
                r_cand_pos <= n_cand_pos;
            end

            r_rd_vld <= w_ctl.cand_re;

            // any register write restarts the stream
            if (w_cfg_hit) begin
                case (i_cfg_idx)
                    sz_pkg::CFG_DOWN_WINDOW: begin
                        r_down_window <= i_cfg_data[sz_pkg::DW_W-1:0];
                    end
                    sz_pkg::CFG_MAX_WINDOW: begin
                        r_max_window <= i_cfg_data[sz_pkg::MW_W-1:0];
                    end
                    sz_pkg::CFG_MULTIPLIER: begin
                        r_multiplier <= i_cfg_data[sz_pkg::MULT_W-1:0];
                    end
                    default: begin
                        r_multiplier <= r_multiplier;
                    end
                endcase
                r_seen     <= '0;
                r_prev     <= '0;
                r_sum      <= '0;
                r_count    <= '0;
                r_down_pos <= '0;
                r_cand_pos <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_price <= i_price_ch.price;
            r_t     <= r_seen;
        end

        if (r_state == sz_pkg::SEQ_START && r_count == '0) begin
            r_cand <= r_price;
        end else if (r_state == sz_pkg::SEQ_OFFSET && w_off_stat.done) begin
            r_cand <= w_cand_calc;
        end

        // serial maximum over the candidate ring, floor of zero
        if (r_state == sz_pkg::SEQ_CAND) begin
            r_scan_k <= '0;
            r_best   <= '0;
        end else begin
            if (w_ctl.cand_re) begin
                r_scan_k <= r_scan_k + 1'b1;
            end
            if (r_rd_vld && (w_cand_rd > r_best)) begin
                r_best <= w_cand_rd;
            end
        end

        if (w_ctl.out_load) begin
            r_out_data <= r_best;
        end
    end

    assign i_price_ch.ready     = w_ctl.in_ready;
    assign o_stop_ch.valid      = r_out_vld;
    assign o_stop_ch.stop_level = r_out_data;

    // Downward move ring
    sz_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_DOWN_WINDOW),
        .ADDR_W(LEN_W)
    ) u_down_ring (
        .i_clk    (i_clk),
        .i_wr_en  (w_ctl.down_we),
        .i_wr_addr(r_down_pos),
        .i_wr_data(w_move),
        .i_rd_en  (w_ctl.down_re),
        .i_rd_addr(r_down_pos),
        .o_rd_data(w_old)
    );

    // Candidate ring
    sz_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_CANDIDATES),
        .ADDR_W(CA_W)
    ) u_cand_ring (
        .i_clk    (i_clk),
        .i_wr_en  (w_ctl.cand_we),
        .i_wr_addr(r_cand_pos),
        .i_wr_data(r_cand),
        .i_rd_en  (w_ctl.cand_re),
        .i_rd_addr(r_scan_k),
        .o_rd_data(w_cand_rd)
    );

    // Bit-serial offset unit
    sz_offset #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W),
        .DIV_W(DIV_W)
    ) u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.off_start),
        .i_sum   (r_sum),
        .i_mult  (r_multiplier),
        .i_count (r_count),
        .o_offset(w_offset),
        .o_stat  (w_off_stat)
    );

`ifndef SYNTHESIS
    // down-move count never exceeds the moves the window holds
    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMP_W'(r_count) <= CMP_W'(w_len)))
        else $error("down-move count exceeds window length");

    // ring write positions stay inside the active windows
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_down_pos < w_len) && ((CW_W + 1)'(r_cand_pos) < (CW_W + 1)'(w_width)))
        else $error("ring position outside active window");

    // the divider is only started idle and with a nonzero divisor
    a_start_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.off_start |-> (r_count != '0) && !w_off_stat.busy)
        else $error("offset unit started busy or with zero count");

    // offset completion is only seen while the sequencer waits for it
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_off_stat.done |-> (r_state == sz_pkg::SEQ_OFFSET))
        else $error("offset done outside offset wait");

    // a result loads only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_load |-> (!r_out_vld || o_stop_ch.ready))
        else $error("result overwrote a pending transfer");
`endif

endmodule
